// ----- design/rdc_pkg.sv -----
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants for the range distinct-count unit: field widths, stream
// packing offsets, operation and status codes, parameter defaults.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int DEF_MAX_ELEMENTS = 4096;
    localparam int DEF_VALUE_BITS   = 16;

    localparam int POS_W     = 13;
    localparam int VAL_IN_W  = 16;
    localparam int CNT_OUT_W = 13;
    localparam int LEN_W     = 13;

    // slave tdata: position, value, left, right (low bit first), padded to 56
    localparam int IN_POS_LSB   = 0;
    localparam int IN_VAL_LSB   = IN_POS_LSB + POS_W;
    localparam int IN_LEFT_LSB  = IN_VAL_LSB + VAL_IN_W;
    localparam int IN_RIGHT_LSB = IN_LEFT_LSB + POS_W;
    localparam int IN_USED_W    = IN_RIGHT_LSB + POS_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((CNT_OUT_W + 7) / 8) * 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

endpackage

// ----- design/rdc_ram.sv -----
// ----------------------------------------------------------------------------
// rdc_ram
// Single-port synchronous RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module rdc_ram #(
    parameter int DEPTH = rdc_pkg::DEF_MAX_ELEMENTS,
    parameter int AW    = $clog2(rdc_pkg::DEF_MAX_ELEMENTS),
    parameter int DW    = rdc_pkg::DEF_VALUE_BITS
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/rdc_walker.sv -----
// ----------------------------------------------------------------------------
// rdc_walker
// Sequencer for the distinct-count window: moves the window bounds one
// element at a time, read-modify-writes the frequency table, handles loads
// that land inside the window, and holds the result register.
// ----------------------------------------------------------------------------
module rdc_walker #(
    parameter int MAX_ELEMENTS = rdc_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_BITS   = rdc_pkg::DEF_VALUE_BITS,
    parameter int AW           = $clog2(MAX_ELEMENTS),
    parameter int CW           = $clog2(MAX_ELEMENTS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_in_op,
    input  logic [rdc_pkg::POS_W-1:0]      i_in_pos,
    input  logic [rdc_pkg::VAL_IN_W-1:0]   i_in_val,
    input  logic [rdc_pkg::POS_W-1:0]      i_in_left,
    input  logic [rdc_pkg::POS_W-1:0]      i_in_right,
    input  logic                           i_cfg_we,
    input  logic [rdc_pkg::LEN_W-1:0]      i_cfg_wdata,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic [rdc_pkg::CNT_OUT_W-1:0]  o_res_count,
    output logic                           o_res_status,
    output logic                           o_elem_we,
    output logic [AW-1:0]                  o_elem_addr,
    output logic [VALUE_BITS-1:0]          o_elem_wdata,
    input  logic [VALUE_BITS-1:0]          i_elem_rdata,
    output logic                           o_freq_we,
    output logic [VALUE_BITS-1:0]          o_freq_addr,
    output logic [CW-1:0]                  o_freq_wdata,
    input  logic [CW-1:0]                  i_freq_rdata
);

    localparam int PW = rdc_pkg::POS_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_PLAN = 3'd2;
    localparam logic [2:0] S_LERD = 3'd3;
    localparam logic [2:0] S_ERD  = 3'd4;
    localparam logic [2:0] S_VRD  = 3'd5;
    localparam logic [2:0] S_FWR  = 3'd6;
    localparam logic [2:0] S_LWR  = 3'd7;

    logic [2:0]            r_state, n_state;
    logic                  r_done,  n_done;
    logic [PW-1:0]         r_len;
    logic [PW-1:0]         r_low,   n_low;
    logic [PW-1:0]         r_high,  n_high;
    logic                  r_built, n_built;
    logic [CW-1:0]         r_distinct, n_distinct;
    logic [PW-1:0]         r_pos,   n_pos;
    logic [PW-1:0]         r_right, n_right;
    logic [VALUE_BITS-1:0] r_val,   n_val;
    logic                  r_dir_in, n_dir_in;
    logic                  r_is_load, n_is_load;
    logic                  r_bad,   n_bad;
    logic [VALUE_BITS-1:0] r_faddr, n_faddr;
    logic [VALUE_BITS-1:0] r_clr,   n_clr;
    logic                  r_out_valid, n_out_valid;
    logic [CW-1:0]         r_out_count, n_out_count;
    logic                  r_out_status, n_out_status;

    logic                  w_accept;
    logic                  w_q_bad;
    logic                  w_ld_bad;
    logic                  w_in_window;
    logic                  w_out_free;
    logic [PW-1:0]         w_step_pos;
    logic [CW-1:0]         w_f_inc;
    logic [CW-1:0]         w_f_dec;

    assign o_in_ready = (r_state == S_IDLE) && !r_done;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_res_ready;

    assign w_q_bad = (i_in_left == '0) || (i_in_left > i_in_right) ||
                     (i_in_right > r_len) ||
                     (32'(i_in_right) > 32'(MAX_ELEMENTS));
    assign w_ld_bad = (i_in_pos == '0) || (32'(i_in_pos) > 32'(MAX_ELEMENTS));
    assign w_in_window = r_built && (i_in_pos >= r_low) && (i_in_pos <= r_high);

    assign w_f_inc = i_freq_rdata + CW'(1);
    assign w_f_dec = i_freq_rdata - CW'(1);

    always_comb begin
        n_state      = r_state;
        n_done       = r_done;
        n_low        = r_low;
        n_high       = r_high;
        n_built      = r_built;
        n_distinct   = r_distinct;
        n_pos        = r_pos;
        n_right      = r_right;
        n_val        = r_val;
        n_dir_in     = r_dir_in;
        n_is_load    = r_is_load;
        n_bad        = r_bad;
        n_faddr      = r_faddr;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        w_step_pos   = r_pos;
        o_elem_we    = 1'b0;
        o_elem_addr  = AW'(r_pos - PW'(1));
        o_elem_wdata = r_val;
        o_freq_we    = 1'b0;
        o_freq_addr  = r_faddr;
        o_freq_wdata = '0;

        if (r_done) begin
            // result waits in a holding slot until the output register frees
            if (w_out_free) begin
                n_out_valid  = 1'b1;
                n_out_count  = r_bad ? '0 : r_distinct;
                n_out_status = r_bad ? rdc_pkg::STATUS_BAD : rdc_pkg::STATUS_OK;
                n_done       = 1'b0;
            end
        end else begin
            unique case (r_state)
                S_CLR: begin
                    o_freq_we   = 1'b1;
                    o_freq_addr = r_clr;
                    n_clr       = r_clr + VALUE_BITS'(1);
                    if (r_clr == '1) begin
                        n_state = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        n_is_load = (i_in_op == rdc_pkg::OP_LOAD);
                        if (i_in_op == rdc_pkg::OP_LOAD) begin
                            n_pos = i_in_pos;
                            n_val = VALUE_BITS'(i_in_val);
                            if (!w_ld_bad) begin
                                n_state = w_in_window ? S_LERD : S_LWR;
                            end
                        end else if (w_q_bad) begin
                            n_bad  = 1'b1;
                            n_done = 1'b1;
                        end else begin
                            n_bad   = 1'b0;
                            n_pos   = i_in_left;
                            n_right = i_in_right;
                            if (!r_built) begin
                                n_low   = i_in_left;
                                n_high  = i_in_left - PW'(1);
                                n_built = 1'b1;
                            end
                            n_state = S_PLAN;
                        end
                    end
                end
                S_PLAN: begin
                    n_state = S_ERD;
                    priority if (r_low > r_pos) begin
                        w_step_pos = r_low - PW'(1);
                        n_low      = w_step_pos;
                        n_dir_in   = 1'b1;
                    end else if (r_high < r_right) begin
                        w_step_pos = r_high + PW'(1);
                        n_high     = w_step_pos;
                        n_dir_in   = 1'b1;
                    end else if (r_low < r_pos) begin
                        w_step_pos = r_low;
                        n_low      = r_low + PW'(1);
                        n_dir_in   = 1'b0;
                    end else if (r_high > r_right) begin
                        w_step_pos = r_high;
                        n_high     = r_high - PW'(1);
                        n_dir_in   = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                    o_elem_addr = AW'(w_step_pos - PW'(1));
                end
                S_LERD: begin
                    n_dir_in = 1'b0;
                    n_state  = S_ERD;
                end
                S_ERD: begin
                    o_freq_addr = i_elem_rdata;
                    n_faddr     = i_elem_rdata;
                    n_state     = S_FWR;
                end
                S_VRD: begin
                    o_freq_addr = r_val;
                    n_faddr     = r_val;
                    n_dir_in    = 1'b1;
                    n_state     = S_FWR;
                end
                S_FWR: begin
                    if (r_dir_in) begin
                        o_freq_we    = 1'b1;
                        o_freq_wdata = w_f_inc;
                        if (w_f_inc == CW'(1)) begin
                            n_distinct = r_distinct + CW'(1);
                        end
                    end else if (i_freq_rdata != '0) begin
                        o_freq_we    = 1'b1;
                        o_freq_wdata = w_f_dec;
                        if (w_f_dec == '0 && r_distinct != '0) begin
                            n_distinct = r_distinct - CW'(1);
                        end
                    end
                    if (r_is_load) begin
                        n_state = r_dir_in ? S_LWR : S_VRD;
                    end else begin
                        n_state = S_PLAN;
                    end
                end
                S_LWR: begin
                    o_elem_we = 1'b1;
                    n_state   = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_done      <= 1'b0;
            r_len       <= '0;
            r_low       <= PW'(1);
            r_high      <= '0;
            r_built     <= 1'b0;
            r_distinct  <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_low       <= n_low;
            r_high      <= n_high;
            r_built     <= n_built;
            r_distinct  <= n_distinct;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_right      <= n_right;
        r_val        <= n_val;
        r_dir_in     <= n_dir_in;
        r_is_load    <= n_is_load;
        r_bad        <= n_bad;
        r_faddr      <= n_faddr;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign o_res_valid  = r_out_valid;
    assign o_res_count  = rdc_pkg::CNT_OUT_W'(r_out_count);
    assign o_res_status = r_out_status;

endmodule

// ----- design/range_distinct_count_unit.sv -----
// ----------------------------------------------------------------------------
// range_distinct_count_unit
// Counts distinct values over a position range of a loaded element store by
// walking a window over the store and keeping a per-value frequency table.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                | payload
//  s_axis   | in  | tvalid / tready          | tuser: op; tdata: pos,val,left,right
//  m_axis   | out | tvalid / tready          | tuser: status; tdata: distinct_count
//  cfg      | in  | we (no stall)            | wdata: length_in_use
//
//  Load: an out-of-range position is dropped; otherwise the element store is
//  written, after a frequency update for the old and new value when the
//  position lies inside the current window. Query: the window bounds move
//  one element at a time, each move an element-store read, a frequency read
//  and a write-back. After reset a clearing pass zeroes the frequency table
//  with s_axis held off. A finished result sits in the output register
//  while the next transfer is taken; a further result waits for it.
// ----------------------------------------------------------------------------
module range_distinct_count_unit #(
    parameter int MAX_ELEMENTS = rdc_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_BITS   = rdc_pkg::DEF_VALUE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [12:0] position, [28:13] value, [41:29] left, [54:42] right, [55] zero
    input  logic [rdc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [0] op
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [12:0] distinct_count, [15:13] zero
    output logic [rdc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // [0] status
    output logic                             o_m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [rdc_pkg::LEN_W-1:0]        i_cfg_wdata
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic                            w_elem_we;
    logic [AW-1:0]                   w_elem_addr;
    logic [VALUE_BITS-1:0]           w_elem_wdata;
    logic [VALUE_BITS-1:0]           w_elem_rdata;
    logic                            w_freq_we;
    logic [VALUE_BITS-1:0]           w_freq_addr;
    logic [CW-1:0]                   w_freq_wdata;
    logic [CW-1:0]                   w_freq_rdata;
    logic [rdc_pkg::CNT_OUT_W-1:0]   w_res_count;

    rdc_walker #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS),
        .AW           (AW),
        .CW           (CW)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_in_op      (i_s_axis_tuser),
        .i_in_pos     (i_s_axis_tdata[rdc_pkg::IN_POS_LSB +: rdc_pkg::POS_W]),
        .i_in_val     (i_s_axis_tdata[rdc_pkg::IN_VAL_LSB +: rdc_pkg::VAL_IN_W]),
        .i_in_left    (i_s_axis_tdata[rdc_pkg::IN_LEFT_LSB +: rdc_pkg::POS_W]),
        .i_in_right   (i_s_axis_tdata[rdc_pkg::IN_RIGHT_LSB +: rdc_pkg::POS_W]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res_count  (w_res_count),
        .o_res_status (o_m_axis_tuser),
        .o_elem_we    (w_elem_we),
        .o_elem_addr  (w_elem_addr),
        .o_elem_wdata (w_elem_wdata),
        .i_elem_rdata (w_elem_rdata),
        .o_freq_we    (w_freq_we),
        .o_freq_addr  (w_freq_addr),
        .o_freq_wdata (w_freq_wdata),
        .i_freq_rdata (w_freq_rdata)
    );

    rdc_ram #(
        .DEPTH   (MAX_ELEMENTS),
        .AW      (AW),
        .DW      (VALUE_BITS)
    ) u_elem_store (
        .i_clk   (i_clk),
        .i_we    (w_elem_we),
        .i_addr  (w_elem_addr),
        .i_wdata (w_elem_wdata),
        .o_rdata (w_elem_rdata)
    );

    rdc_ram #(
        .DEPTH   (2 ** VALUE_BITS),
        .AW      (VALUE_BITS),
        .DW      (CW)
    ) u_freq_table (
        .i_clk   (i_clk),
        .i_we    (w_freq_we),
        .i_addr  (w_freq_addr),
        .i_wdata (w_freq_wdata),
        .o_rdata (w_freq_rdata)
    );

    assign o_m_axis_tdata = rdc_pkg::OUT_TDATA_W'(w_res_count);

    // frequency table is only written while s_axis is held off
    a_freq_wr_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_freq_we |-> !o_s_axis_tready)
        else $error("frequency write while input ready");

    a_single_mem_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_freq_we |-> !w_elem_we)
        else $error("element and frequency writes in the same cycle");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == rdc_pkg::STATUS_BAD)
            |-> (w_res_count == '0))
        else $error("bad-range result carries a nonzero count");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_s_axis_tready)
        else $error("input ready before frequency clear");

endmodule
